### design/sparse_vector_merge_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Sparse vector merge engine assertion macros
// Clocked assertion wrappers for the engine module.
// ----------------------------------------------------------------------------
`ifndef SPARSE_VECTOR_MERGE_ENGINE_UNIT_ASSERT_SVH
`define SPARSE_VECTOR_MERGE_ENGINE_UNIT_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define SVME_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// A condition that must never be seen at a clock edge out of reset.
`define SVME_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error(msg);

`endif

### design/svme_pkg.sv
// ----------------------------------------------------------------------------
// Sparse vector merge engine package
// Widths, codes and control structures shared by the engine modules.
// ----------------------------------------------------------------------------
package svme_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int INDEX_W = 16;
	localparam int VALUE_W = 32;
	localparam int RES_W = 64;
	localparam int ERR_W = 2;
	localparam int ERR_FULL_BIT = 0;
	localparam int ERR_ORDER_BIT = 1;

	typedef enum logic [1:0] {
		KIND_A = 2'd0,
		KIND_B = 2'd1,
		KIND_COMPUTE = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_DOT = 2'd2,
		MODE_NEG = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_DOT,
		ST_DOT_EMIT
	} state_t;

	// Operand selection and accumulator control for the shared unit.
	typedef struct packed {
		logic use_a;
		logic neg_a;
		logic use_b;
		logic neg_b;
		logic mul_en;
		logic acc_clr;
	} alu_ctl_t;

	// Why a load beat was dropped by a store.
	typedef struct packed {
		logic drop_full;
		logic drop_order;
	} load_st_t;

endpackage

### design/sparse_vector_merge_engine_unit.sv
// ----------------------------------------------------------------------------
// Sparse vector merge engine
// Loads two sparse vectors and merges them into a sum, difference, negation
// or dot product.
// ----------------------------------------------------------------------------
// A load beat (kind A or B) is offered to its store and produces nothing;
// kind 3 is taken and ignored. After a compute beat is taken the input
// stays not ready while one sequencer walks both stores through a single
// shared arithmetic unit. Add, subtract and negate produce one result beat
// per cycle while the result channel is not stalled, one per entry of the
// union (of vector A alone for negate), or one empty-result beat. Dot takes
// at most a_count + b_count merge steps, then drains the multiplier register
// and delivers the single result beat. Backpressure on the result channel
// holds the merge walk and the dot result beat. The mode register may be
// written at any time the engine is idle.
module sparse_vector_merge_engine_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [1:0]                    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic        [1:0]                    kind,
	input  logic        [svme_pkg::INDEX_W-1:0]  index,
	input  logic signed [svme_pkg::VALUE_W-1:0]  value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic        [svme_pkg::INDEX_W-1:0]  index_res,
	output logic signed [svme_pkg::RES_W-1:0]    value_res,
	output logic                                 has_entry,
	output logic                                 last,
	output logic        [svme_pkg::ERR_W-1:0]    error,
	output logic                                 saturated
);

	`include "sparse_vector_merge_engine_unit_assert.svh"

	svme_pkg::state_t   state_q;
	svme_pkg::state_t   state_nx;
	svme_pkg::mode_t    mode_q;
	svme_pkg::alu_ctl_t alu_ctl;
	svme_pkg::load_st_t a_ld_st;
	svme_pkg::load_st_t b_ld_st;

	logic        [svme_pkg::CNT_W-1:0]   i_q;
	logic        [svme_pkg::CNT_W-1:0]   j_q;
	logic        [svme_pkg::CNT_W-1:0]   a_count;
	logic        [svme_pkg::CNT_W-1:0]   b_count;
	logic        [svme_pkg::INDEX_W-1:0] a_idx;
	logic        [svme_pkg::INDEX_W-1:0] b_idx;
	logic signed [svme_pkg::VALUE_W-1:0] a_val;
	logic signed [svme_pkg::VALUE_W-1:0] b_val;
	logic signed [svme_pkg::VALUE_W-1:0] sum_res;
	logic                                sum_sat;
	logic signed [svme_pkg::RES_W-1:0]   acc;
	logic                                acc_sat;
	logic                                prod_pend;
	logic        [svme_pkg::ERR_W-1:0]   err_q;

	logic in_fire;
	logic is_compute;
	logic ld_a;
	logic ld_b;
	logic slot_free;
	logic a_left;
	logic b_left;
	logic take_a;
	logic take_b;
	logic take_both;
	logic a_rem;
	logic b_rem;
	logic adv_a;
	logic adv_b;
	logic ptr_clr;
	logic done;
	logic ld_out;

	logic        [svme_pkg::INDEX_W-1:0] nx_index;
	logic signed [svme_pkg::RES_W-1:0]   nx_value;
	logic                                nx_has;
	logic                                nx_last;
	logic                                nx_sat;

	logic                                out_valid_q;
	logic        [svme_pkg::INDEX_W-1:0] index_res_q;
	logic signed [svme_pkg::RES_W-1:0]   value_res_q;
	logic                                has_entry_q;
	logic                                last_q;
	logic        [svme_pkg::ERR_W-1:0]   error_q;
	logic                                saturated_q;

	// The mode is only taken between computes so a merge never sees it change.
	assign cfg_ready = (state_q == svme_pkg::ST_IDLE);
	assign in_ready = (state_q == svme_pkg::ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign is_compute = (kind == svme_pkg::KIND_COMPUTE);
	assign ld_a = in_fire && (kind == svme_pkg::KIND_A);
	assign ld_b = in_fire && (kind == svme_pkg::KIND_B);
	assign slot_free = !out_valid_q || out_ready;

	svme_store u_store_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld_a),
		.wr_index (index),
		.wr_value (value),
		.clr      (done),
		.rd_ptr   (i_q),
		.count    (a_count),
		.rd_index (a_idx),
		.rd_value (a_val),
		.load_st  (a_ld_st)
	);

	svme_store u_store_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld_b),
		.wr_index (index),
		.wr_value (value),
		.clr      (done),
		.rd_ptr   (j_q),
		.count    (b_count),
		.rd_index (b_idx),
		.rd_value (b_val),
		.load_st  (b_ld_st)
	);

	svme_alu u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (alu_ctl),
		.a_val     (a_val),
		.b_val     (b_val),
		.sum_res   (sum_res),
		.sum_sat   (sum_sat),
		.acc       (acc),
		.acc_sat   (acc_sat),
		.prod_pend (prod_pend)
	);

	// Negate walks vector A alone, so B counts as exhausted in that mode.
	assign a_left = (i_q < a_count);
	assign b_left = (j_q < b_count) && (mode_q != svme_pkg::MODE_NEG);
	assign take_a = a_left && (!b_left || (a_idx < b_idx));
	assign take_b = b_left && (!a_left || (b_idx < a_idx));
	assign take_both = a_left && b_left && (a_idx == b_idx);
	assign a_rem = ((i_q + svme_pkg::CNT_W'(adv_a)) < a_count);
	assign b_rem = ((j_q + svme_pkg::CNT_W'(adv_b)) < b_count)
		&& (mode_q != svme_pkg::MODE_NEG);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			svme_pkg::ST_IDLE: begin
				if (in_fire && is_compute) begin
					state_nx = (mode_q == svme_pkg::MODE_DOT)
						? svme_pkg::ST_DOT : svme_pkg::ST_MERGE;
				end
			end
			svme_pkg::ST_MERGE: begin
				if (done) begin
					state_nx = svme_pkg::ST_IDLE;
				end
			end
			svme_pkg::ST_DOT: begin
				if (!(a_left && b_left)) begin
					state_nx = svme_pkg::ST_DOT_EMIT;
				end
			end
			svme_pkg::ST_DOT_EMIT: begin
				if (done) begin
					state_nx = svme_pkg::ST_IDLE;
				end
			end
			default: state_nx = svme_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		alu_ctl = '0;
		adv_a = 1'b0;
		adv_b = 1'b0;
		ptr_clr = 1'b0;
		done = 1'b0;
		ld_out = 1'b0;
		nx_index = '0;
		nx_value = '0;
		nx_has = 1'b0;
		nx_last = 1'b0;
		nx_sat = 1'b0;
		unique case (state_q)
			svme_pkg::ST_IDLE: begin
				if (in_fire && is_compute) begin
					ptr_clr = 1'b1;
					alu_ctl.acc_clr = 1'b1;
				end
			end
			svme_pkg::ST_MERGE: begin
				if (slot_free) begin
					ld_out = 1'b1;
					if (a_left || b_left) begin
						alu_ctl.use_a = take_a || take_both;
						alu_ctl.neg_a = (mode_q == svme_pkg::MODE_NEG);
						alu_ctl.use_b = take_b || take_both;
						alu_ctl.neg_b = (mode_q == svme_pkg::MODE_SUB);
						adv_a = take_a || take_both;
						adv_b = take_b || take_both;
						nx_index = adv_a ? a_idx : b_idx;
						nx_value = svme_pkg::RES_W'(sum_res);
						nx_has = 1'b1;
						nx_sat = sum_sat;
						nx_last = !a_rem && !b_rem;
					end else begin
						// Nothing left to walk: report an empty result vector.
						nx_last = 1'b1;
					end
					done = nx_last;
				end
			end
			svme_pkg::ST_DOT: begin
				if (a_left && b_left) begin
					adv_a = !(b_idx < a_idx);
					adv_b = !(a_idx < b_idx);
					alu_ctl.mul_en = take_both;
				end
			end
			svme_pkg::ST_DOT_EMIT: begin
				// The last product must reach the accumulator before it is shown.
				if (slot_free && !prod_pend) begin
					ld_out = 1'b1;
					nx_value = acc;
					nx_has = 1'b1;
					nx_last = 1'b1;
					nx_sat = acc_sat;
					done = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svme_pkg::ST_IDLE;
			mode_q <= svme_pkg::MODE_ADD;
			i_q <= '0;
			j_q <= '0;
			err_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				mode_q <= svme_pkg::mode_t'(cfg_data);
			end
			if (ptr_clr) begin
				i_q <= '0;
				j_q <= '0;
			end else begin
				i_q <= i_q + svme_pkg::CNT_W'(adv_a);
				j_q <= j_q + svme_pkg::CNT_W'(adv_b);
			end
			if (done) begin
				err_q <= '0;
			end else begin
				err_q[svme_pkg::ERR_FULL_BIT] <= err_q[svme_pkg::ERR_FULL_BIT]
					| a_ld_st.drop_full | b_ld_st.drop_full;
				err_q[svme_pkg::ERR_ORDER_BIT] <= err_q[svme_pkg::ERR_ORDER_BIT]
					| a_ld_st.drop_order | b_ld_st.drop_order;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			index_res_q <= nx_index;
			value_res_q <= nx_value;
			has_entry_q <= nx_has;
			last_q <= nx_last;
			error_q <= err_q;
			saturated_q <= nx_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign index_res = index_res_q;
	assign value_res = value_res_q;
	assign has_entry = has_entry_q;
	assign last = last_q;
	assign error = error_q;
	assign saturated = saturated_q;

	`SVME_ASSERT(a_ptr_in_range, (state_q != svme_pkg::ST_IDLE) |-> ((i_q <= a_count) && (j_q <= b_count)), "merge pointer ran past a store count")
	`SVME_ASSERT(stores_cleared, done |=> ((a_count == '0) && (b_count == '0) && (err_q == '0)), "stores or error flags not cleared after compute")
	`SVME_NEVER(stray_product, prod_pend && (state_q != svme_pkg::ST_DOT) && (state_q != svme_pkg::ST_DOT_EMIT), "product pending outside a dot compute")
	`SVME_ASSERT(count_bounded, (a_count <= svme_pkg::CNT_W'(svme_pkg::MAX_ENTRIES)) && (b_count <= svme_pkg::CNT_W'(svme_pkg::MAX_ENTRIES)), "store count beyond capacity")

endmodule

### design/svme_store.sv
// ----------------------------------------------------------------------------
// Sparse vector store
// Holds one vector as ascending index/value pairs with a fill count.
// ----------------------------------------------------------------------------
module svme_store (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   ld,
	input  logic        [svme_pkg::INDEX_W-1:0]    wr_index,
	input  logic signed [svme_pkg::VALUE_W-1:0]    wr_value,
	input  logic                                   clr,
	input  logic        [svme_pkg::CNT_W-1:0]      rd_ptr,
	output logic        [svme_pkg::CNT_W-1:0]      count,
	output logic        [svme_pkg::INDEX_W-1:0]    rd_index,
	output logic signed [svme_pkg::VALUE_W-1:0]    rd_value,
	output svme_pkg::load_st_t                     load_st
);

	logic        [svme_pkg::INDEX_W-1:0] index_arr_q [svme_pkg::MAX_ENTRIES];
	logic signed [svme_pkg::VALUE_W-1:0] value_arr_q [svme_pkg::MAX_ENTRIES];
	logic        [svme_pkg::CNT_W-1:0]   count_q;
	logic        [svme_pkg::INDEX_W-1:0] last_index_q;
	logic                                full;
	logic                                out_of_order;
	logic                                wr_en;

	assign full = (count_q == svme_pkg::CNT_W'(svme_pkg::MAX_ENTRIES));
	// The last written index is kept aside so the order check needs no second read.
	assign out_of_order = (count_q != '0) && (wr_index <= last_index_q);
	assign wr_en = ld && !full && !out_of_order;

	assign load_st.drop_full = ld && full;
	assign load_st.drop_order = ld && !full && out_of_order;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			index_arr_q[count_q[svme_pkg::IDX_W-1:0]] <= wr_index;
			value_arr_q[count_q[svme_pkg::IDX_W-1:0]] <= wr_value;
			last_index_q <= wr_index;
		end
	end

	assign count = count_q;
	assign rd_index = index_arr_q[rd_ptr[svme_pkg::IDX_W-1:0]];
	assign rd_value = value_arr_q[rd_ptr[svme_pkg::IDX_W-1:0]];

endmodule

### design/svme_alu.sv
// ----------------------------------------------------------------------------
// Sparse vector merge arithmetic unit
// Saturating add/subtract/negate path and a registered multiply-accumulate.
// ----------------------------------------------------------------------------
module svme_alu (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  svme_pkg::alu_ctl_t                   ctl,
	input  logic signed [svme_pkg::VALUE_W-1:0]  a_val,
	input  logic signed [svme_pkg::VALUE_W-1:0]  b_val,
	output logic signed [svme_pkg::VALUE_W-1:0]  sum_res,
	output logic                                 sum_sat,
	output logic signed [svme_pkg::RES_W-1:0]    acc,
	output logic                                 acc_sat,
	output logic                                 prod_pend
);

	localparam int SUM_W = svme_pkg::VALUE_W + 2;
	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (svme_pkg::VALUE_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(64'sd1 <<< (svme_pkg::VALUE_W - 1));

	logic signed [SUM_W-1:0]            a_ext;
	logic signed [SUM_W-1:0]            b_ext;
	logic signed [SUM_W-1:0]            sum_w;
	logic signed [svme_pkg::RES_W-1:0]  prod_w;
	logic signed [svme_pkg::RES_W-1:0]  prod_s1;
	logic                               prod_vld_s1;
	logic signed [svme_pkg::RES_W:0]    acc_sum;
	logic signed [svme_pkg::RES_W-1:0]  acc_q;
	logic                               acc_sat_q;

	always_comb begin
		a_ext = '0;
		b_ext = '0;
		if (ctl.use_a) begin
			a_ext = ctl.neg_a ? -SUM_W'(a_val) : SUM_W'(a_val);
		end
		if (ctl.use_b) begin
			b_ext = ctl.neg_b ? -SUM_W'(b_val) : SUM_W'(b_val);
		end
		sum_w = a_ext + b_ext;
		sum_sat = 1'b0;
		if (sum_w > SUM_MAX) begin
			sum_res = SUM_MAX[svme_pkg::VALUE_W-1:0];
			sum_sat = 1'b1;
		end else if (sum_w < SUM_MIN) begin
			sum_res = SUM_MIN[svme_pkg::VALUE_W-1:0];
			sum_sat = 1'b1;
		end else begin
			sum_res = sum_w[svme_pkg::VALUE_W-1:0];
		end
	end

	assign prod_w = svme_pkg::RES_W'(a_val) * svme_pkg::RES_W'(b_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= prod_w;
		end
	end

	// One extra bit shows a signed overflow of the 64-bit accumulator.
	assign acc_sum = {acc_q[svme_pkg::RES_W-1], acc_q} + {prod_s1[svme_pkg::RES_W-1], prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			acc_sat_q <= 1'b0;
		end else if (ctl.acc_clr) begin
			acc_q <= '0;
			acc_sat_q <= 1'b0;
		end else if (prod_vld_s1) begin
			if (acc_sum[svme_pkg::RES_W] != acc_sum[svme_pkg::RES_W-1]) begin
				acc_q <= acc_sum[svme_pkg::RES_W]
					? {1'b1, {(svme_pkg::RES_W - 1){1'b0}}}
					: {1'b0, {(svme_pkg::RES_W - 1){1'b1}}};
				acc_sat_q <= 1'b1;
			end else begin
				acc_q <= acc_sum[svme_pkg::RES_W-1:0];
			end
		end
	end

	assign acc = acc_q;
	assign acc_sat = acc_sat_q;
	assign prod_pend = prod_vld_s1;

endmodule

### tb/tb_sparse_vector_merge_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse vector merge engine testbench
// Loads pairs of sparse vectors, runs add, subtract, dot and negate merges,
// and checks every result beat against an in-bench prediction of the merge.
// Directed cases come first, then random load/compute phases under random
// sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sparse_vector_merge_engine_unit;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS = 210;
	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;
	localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint MIN64 = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [svme_pkg::INDEX_W-1:0]        index_res;
		logic signed [svme_pkg::RES_W-1:0]   value_res;
		logic                                has_entry;
		logic                                last;
		logic [svme_pkg::ERR_W-1:0]          error;
		logic                                saturated;
	} merge_result_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_data = 2'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	svme_pkg::kind_t kind = svme_pkg::KIND_A;
	logic [svme_pkg::INDEX_W-1:0] index = '0;
	logic signed [svme_pkg::VALUE_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [svme_pkg::INDEX_W-1:0] index_res;
	logic signed [svme_pkg::RES_W-1:0] value_res;
	logic has_entry;
	logic last;
	logic [svme_pkg::ERR_W-1:0] error;
	logic saturated;

	// Predicted engine state: store 0 is vector A, store 1 is vector B.
	logic [svme_pkg::INDEX_W-1:0] st_idx [2][svme_pkg::MAX_ENTRIES];
	logic signed [svme_pkg::VALUE_W-1:0] st_val [2][svme_pkg::MAX_ENTRIES];
	int st_cnt [2] = '{0, 0};
	logic [svme_pkg::ERR_W-1:0] err_flags = '0;
	svme_pkg::mode_t cur_mode = svme_pkg::MODE_ADD;

	merge_result_t merge_results_q[$];

	int cycle_count = 0;
	int burst_left = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int clipped_seen = 0;
	int flagged_seen = 0;
	int empty_seen = 0;
	int mode_runs [4] = '{0, 0, 0, 0};
	int stall_left = 0;
	int stall_style = 0;

	sparse_vector_merge_engine_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.index     (index),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.index_res (index_res),
		.value_res (value_res),
		.has_entry (has_entry),
		.last      (last),
		.error     (error),
		.saturated (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding",
			cycle_count, merge_results_q.size());
		$display("Simulation FAILED");
		$finish;
	end

	// The receiver switches between stall styles over windows of random length.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left <= $urandom_range(16, 80);
			stall_style <= $urandom_range(0, 3);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((cycle_count % 20) < 3);
		endcase
	end

	function automatic longint clip32(input longint v, output bit clipped);
		clipped = 1'b0;
		if (v > MAX32) begin
			clipped = 1'b1;
			return MAX32;
		end
		if (v < MIN32) begin
			clipped = 1'b1;
			return MIN32;
		end
		return v;
	endfunction

	function automatic merge_result_t make_result(input logic [svme_pkg::INDEX_W-1:0] at,
			input longint v, input bit has, input bit clipped);
		merge_result_t r;
		r.index_res = at;
		r.value_res = v;
		r.has_entry = has;
		r.last = 1'b0;
		r.error = err_flags;
		r.saturated = clipped;
		return r;
	endfunction

	// Applies one accepted input beat to the predicted state and queues the
	// result beats that a compute produces.
	function automatic void predict_merge(input svme_pkg::kind_t k,
			input logic [svme_pkg::INDEX_W-1:0] idx,
			input logic signed [svme_pkg::VALUE_W-1:0] val);
		int sel;
		int i;
		int j;
		longint acc;
		longint prod;
		longint sum;
		longint v;
		bit clipped;
		logic [svme_pkg::INDEX_W-1:0] at;
		merge_result_t batch[$];

		case (k)
			svme_pkg::KIND_A, svme_pkg::KIND_B: begin
				sel = (k == svme_pkg::KIND_B) ? 1 : 0;
				if (st_cnt[sel] >= svme_pkg::MAX_ENTRIES) begin
					err_flags[svme_pkg::ERR_FULL_BIT] = 1'b1;
				end else if (st_cnt[sel] > 0 && idx <= st_idx[sel][st_cnt[sel] - 1]) begin
					err_flags[svme_pkg::ERR_ORDER_BIT] = 1'b1;
				end else begin
					st_idx[sel][st_cnt[sel]] = idx;
					st_val[sel][st_cnt[sel]] = val;
					st_cnt[sel]++;
				end
			end
			svme_pkg::KIND_COMPUTE: begin
				i = 0;
				j = 0;
				if (cur_mode == svme_pkg::MODE_DOT) begin
					acc = 0;
					clipped = 1'b0;
					while (i < st_cnt[0] && j < st_cnt[1]) begin
						if (st_idx[0][i] < st_idx[1][j]) begin
							i++;
						end else if (st_idx[1][j] < st_idx[0][i]) begin
							j++;
						end else begin
							prod = longint'(st_val[0][i]) * longint'(st_val[1][j]);
							sum = acc + prod;
							// Signed overflow: both addends agree in sign, the sum does not.
							if (acc[63] == prod[63] && sum[63] != acc[63]) begin
								clipped = 1'b1;
								sum = acc[63] ? MIN64 : MAX64;
							end
							acc = sum;
							i++;
							j++;
						end
					end
					batch = {batch, make_result('0, acc, 1'b1, clipped)};
				end else if (cur_mode == svme_pkg::MODE_NEG) begin
					for (i = 0; i < st_cnt[0]; i++) begin
						v = clip32(-longint'(st_val[0][i]), clipped);
						batch = {batch, make_result(st_idx[0][i], v, 1'b1, clipped)};
					end
				end else begin
					while (i < st_cnt[0] || j < st_cnt[1]) begin
						if (j >= st_cnt[1] || (i < st_cnt[0] && st_idx[0][i] < st_idx[1][j])) begin
							at = st_idx[0][i];
							v = st_val[0][i];
							i++;
						end else if (i >= st_cnt[0] || st_idx[1][j] < st_idx[0][i]) begin
							at = st_idx[1][j];
							v = (cur_mode == svme_pkg::MODE_SUB) ? -longint'(st_val[1][j])
								: longint'(st_val[1][j]);
							j++;
						end else begin
							at = st_idx[0][i];
							v = (cur_mode == svme_pkg::MODE_SUB)
								? longint'(st_val[0][i]) - longint'(st_val[1][j])
								: longint'(st_val[0][i]) + longint'(st_val[1][j]);
							i++;
							j++;
						end
						v = clip32(v, clipped);
						batch = {batch, make_result(at, v, 1'b1, clipped)};
					end
				end
				if (batch.size() == 0)
					batch = {batch, make_result('0, 0, 1'b0, 1'b0)};
				batch[batch.size() - 1].last = 1'b1;
				merge_results_q = {merge_results_q, batch};
				mode_runs[cur_mode]++;
				st_cnt[0] = 0;
				st_cnt[1] = 0;
				err_flags = '0;
			end
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input merge_result_t exp_r,
			input merge_result_t got_r);
		mismatches++;
		if (mismatches <= 10) begin
			$display("Mismatch at cycle %0d (%s): expected idx %0d val %0d has %0b last %0b err %0b sat %0b",
				cycle_count, what, exp_r.index_res, $signed(exp_r.value_res), exp_r.has_entry,
				exp_r.last, exp_r.error, exp_r.saturated);
			$display("    got idx %0d val %0d has %0b last %0b err %0b sat %0b",
				got_r.index_res, $signed(got_r.value_res), got_r.has_entry, got_r.last,
				got_r.error, got_r.saturated);
		end
	endtask

	always @(posedge clk) begin : check_results
		merge_result_t got_r;
		merge_result_t exp_r;
		string bad;

		if (arst_n && out_valid && out_ready) begin
			got_r.index_res = index_res;
			got_r.value_res = value_res;
			got_r.has_entry = has_entry;
			got_r.last = last;
			got_r.error = error;
			got_r.saturated = saturated;
			results_seen++;
			if (merge_results_q.size() == 0) begin
				report_mismatch("result beat with none expected", '0, got_r);
			end else begin
				exp_r = merge_results_q.pop_front();
				bad = "";
				if (got_r.index_res !== exp_r.index_res) bad = {bad, " index_res"};
				if (got_r.value_res !== exp_r.value_res) bad = {bad, " value_res"};
				if (got_r.has_entry !== exp_r.has_entry) bad = {bad, " has_entry"};
				if (got_r.last !== exp_r.last) bad = {bad, " last"};
				if (got_r.error !== exp_r.error) bad = {bad, " error"};
				if (got_r.saturated !== exp_r.saturated) bad = {bad, " saturated"};
				if (bad != "")
					report_mismatch({"wrong", bad}, exp_r, got_r);
				if (exp_r.saturated) clipped_seen++;
				if (exp_r.error != '0) flagged_seen++;
				if (!exp_r.has_entry) empty_seen++;
			end
		end
	end

	// Sends one input beat; the sender pauses only between bursts.
	task automatic send_item(input svme_pkg::kind_t k, input logic [svme_pkg::INDEX_W-1:0] idx,
			input logic signed [svme_pkg::VALUE_W-1:0] val);
		int gap;

		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		index <= idx;
		value <= val;
		do @(posedge clk); while (!in_ready);
		predict_merge(k, idx, val);
		if (k != svme_pkg::KIND_NONE) items_sent++;
	endtask

	// Stops sending and waits until every predicted result beat has come back.
	// The pause afterwards covers a trailing load that returns nothing.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (merge_results_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input svme_pkg::mode_t m);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode = m;
	endtask

	function automatic logic signed [svme_pkg::VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom_range(0, 32'h0003_0000);
			3: return -$signed({1'b0, 31'($urandom_range(0, 32'h0003_0000))});
			default: return $urandom;
		endcase
	endfunction

	task automatic test_empty_vectors();
		set_mode(svme_pkg::MODE_NEG);
		send_item(svme_pkg::KIND_COMPUTE, 16'hFFFF, 32'sh7FFF_FFFF);
		set_mode(svme_pkg::MODE_DOT);
		send_item(svme_pkg::KIND_COMPUTE, 16'h0000, 32'sh8000_0000);
		set_mode(svme_pkg::MODE_ADD);
		// An unknown kind is taken and must leave no trace.
		send_item(svme_pkg::KIND_NONE, 16'hA5A5, 32'sh1234_5678);
		send_item(svme_pkg::KIND_COMPUTE, 16'h0000, 32'sh0000_0000);
	endtask

	task automatic test_add_sub_extremes();
		set_mode(svme_pkg::MODE_ADD);
		send_item(svme_pkg::KIND_A, 16'd0, 32'sh7FFF_FFFF);
		send_item(svme_pkg::KIND_B, 16'd0, 32'sd1);
		send_item(svme_pkg::KIND_B, 16'd100, 32'sd12345);
		send_item(svme_pkg::KIND_A, 16'd65535, 32'sh8000_0000);
		send_item(svme_pkg::KIND_B, 16'd65535, -32'sd1);
		send_item(svme_pkg::KIND_COMPUTE, 16'd0, 32'sd0);
		set_mode(svme_pkg::MODE_SUB);
		send_item(svme_pkg::KIND_A, 16'd0, 32'sh8000_0000);
		send_item(svme_pkg::KIND_B, 16'd0, 32'sd1);
		send_item(svme_pkg::KIND_B, 16'd7, 32'sh8000_0000);
		send_item(svme_pkg::KIND_COMPUTE, 16'd0, 32'sd0);
	endtask

	task automatic test_negate();
		set_mode(svme_pkg::MODE_NEG);
		send_item(svme_pkg::KIND_A, 16'd3, 32'sh8000_0000);
		send_item(svme_pkg::KIND_B, 16'd4, 32'sd99);
		send_item(svme_pkg::KIND_A, 16'd40000, 32'sh0001_8000);
		send_item(svme_pkg::KIND_A, 16'd65535, 32'sh7FFF_FFFF);
		send_item(svme_pkg::KIND_COMPUTE, 16'd0, 32'sd0);
	endtask

	task automatic test_dot_saturation();
		set_mode(svme_pkg::MODE_DOT);
		send_item(svme_pkg::KIND_A, 16'd1, 32'sh8000_0000);
		send_item(svme_pkg::KIND_B, 16'd1, 32'sh8000_0000);
		send_item(svme_pkg::KIND_A, 16'd2, 32'sh8000_0000);
		send_item(svme_pkg::KIND_A, 16'd5, 32'sd7);
		send_item(svme_pkg::KIND_B, 16'd2, 32'sh8000_0000);
		send_item(svme_pkg::KIND_B, 16'd6, 32'sd3);
		send_item(svme_pkg::KIND_COMPUTE, 16'd0, 32'sd0);
	endtask

	task automatic test_store_errors();
		set_mode(svme_pkg::MODE_ADD);
		send_item(svme_pkg::KIND_A, 16'd10, 32'sd1000);
		send_item(svme_pkg::KIND_A, 16'd10, 32'sd2000);
		send_item(svme_pkg::KIND_A, 16'd9, 32'sd3000);
		// One beat more than vector B can hold.
		for (int n = 0; n <= svme_pkg::MAX_ENTRIES; n++)
			send_item(svme_pkg::KIND_B, 16'(n * 3), rand_value());
		send_item(svme_pkg::KIND_COMPUTE, 16'd0, 32'sd0);
	endtask

	task automatic pick_indices(ref logic [svme_pkg::INDEX_W-1:0] list[$], input int count,
			input bit dense);
		int at;

		list.delete();
		at = dense ? $urandom_range(0, 3) : $urandom_range(0, 30000);
		repeat (count) begin
			if (at > 65535) break;
			list = {list, at[svme_pkg::INDEX_W-1:0]};
			at += dense ? $urandom_range(1, 3) : $urandom_range(1, 6000);
		end
	endtask

	// One well-formed load sequence with random content, a little noise, and
	// a compute at the end.
	task automatic run_random_phase();
		logic [svme_pkg::INDEX_W-1:0] a_list[$];
		logic [svme_pkg::INDEX_W-1:0] b_list[$];
		logic [svme_pkg::INDEX_W-1:0] tmp[$];
		int style;
		int i;
		int j;
		bit pick_a;

		if ($urandom_range(0, 2) != 0)
			set_mode(svme_pkg::mode_t'($urandom_range(0, 3)));
		style = $urandom_range(0, 2);
		pick_indices(a_list, ($urandom_range(0, 3) == 0) ? $urandom_range(12, 18)
			: $urandom_range(0, 8), style == 0);
		if (style == 2) begin
			pick_indices(tmp, 0, 1'b0);
			foreach (a_list[n])
				if ($urandom_range(0, 3) != 0) tmp = {tmp, a_list[n]};
			b_list = tmp;
		end else begin
			pick_indices(b_list, ($urandom_range(0, 3) == 0) ? $urandom_range(12, 18)
				: $urandom_range(0, 8), style == 0);
		end
		i = 0;
		j = 0;
		while (i < a_list.size() || j < b_list.size()) begin
			pick_a = (j >= b_list.size()) || (i < a_list.size() && $urandom_range(0, 1) == 1);
			if ($urandom_range(0, 11) == 0) begin
				if (pick_a && i > 0)
					send_item(svme_pkg::KIND_A, a_list[$urandom_range(0, i - 1)], rand_value());
				else if (!pick_a && j > 0)
					send_item(svme_pkg::KIND_B, b_list[$urandom_range(0, j - 1)], rand_value());
				else
					send_item(svme_pkg::KIND_NONE, 16'($urandom), $urandom);
			end
			if (pick_a) begin
				send_item(svme_pkg::KIND_A, a_list[i], rand_value());
				i++;
			end else begin
				send_item(svme_pkg::KIND_B, b_list[j], rand_value());
				j++;
			end
		end
		send_item(svme_pkg::KIND_COMPUTE, 16'($urandom), $urandom);
	endtask

	task automatic test_random_phases();
		int target;

		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target)
			run_random_phase();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_vectors();
		test_add_sub_extremes();
		test_negate();
		test_dot_saturation();
		test_store_errors();
		test_random_phases();
		set_mode(svme_pkg::MODE_NEG);
		wait_idle();

		$display("Checked %0d result beats from %0d input beats: %0d add, %0d subtract, %0d dot, %0d negate computes",
			results_seen, items_sent, mode_runs[svme_pkg::MODE_ADD],
			mode_runs[svme_pkg::MODE_SUB], mode_runs[svme_pkg::MODE_DOT],
			mode_runs[svme_pkg::MODE_NEG]);
		$display("%0d clipped results, %0d results with store errors, %0d empty vectors, %0d mismatches",
			clipped_seen, flagged_seen, empty_seen, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/svme_pkg.sv
design/svme_store.sv
design/svme_alu.sv
design/sparse_vector_merge_engine_unit.sv
tb/tb_sparse_vector_merge_engine_unit.sv
